// ===== sv/psch_pkg.sv =====
// package for the periodic message scheduler
// holds payload structs, opcodes, fsm states and slot reset tables
// no dependencies
package psch_pkg;

  localparam int NUM_SLOTS_DEF = 7;
  localparam int SLOT_CAP      = 16;
  localparam int MAX_FIRE      = 7;

  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_SET_EN  = 2'd1;
  localparam logic [1:0] OP_SET_PER = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  spec;
    logic        enable;
    logic [15:0] period;
  } cmd_t;

  typedef struct packed {
    logic [2:0] slot;
    logic [2:0] tag;
    logic       last;
  } res_t;

  typedef struct packed {
    logic rd;
    logic cnt_we;
    logic per_we;
    logic en_we;
    logic en_val;
  } store_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FLUSH,
    ST_SET_RD,
    ST_SET_WR
  } state_t;

  function automatic logic [15:0] cnt_init(input logic [3:0] idx);
    logic [15:0] v;
    case (idx)
      4'd0: v = 16'd0;
      4'd1: v = 16'd33;
      4'd2: v = 16'd10;
      4'd3: v = 16'd66;
      4'd4: v = 16'd500;
      4'd5: v = 16'd250;
      4'd6: v = 16'd750;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] per_init(input logic [3:0] idx);
    logic [15:0] v;
    case (idx)
      4'd0: v = 16'd100;
      4'd1: v = 16'd100;
      4'd2: v = 16'd1000;
      4'd3: v = 16'd100;
      4'd4: v = 16'd1000;
      4'd5: v = 16'd500;
      4'd6: v = 16'd1000;
      default: v = 16'd1000;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/psch_store.sv =====
// slot store: countdown and period memories with registered reads
// plus enable flops; entries not yet written read as their reset values
// depends on psch_pkg
module psch_store #(
  parameter int NUM_SLOTS = psch_pkg::NUM_SLOTS_DEF,
  parameter int AW        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  psch_pkg::store_ctl_t ctl,
  input  logic [AW-1:0]        rd_addr,
  input  logic [AW-1:0]        wr_addr,
  input  logic [15:0]          cnt_wdata,
  input  logic [15:0]          per_wdata,
  output logic [15:0]          cnt_rdata,
  output logic [15:0]          per_rdata,
  output logic [NUM_SLOTS-1:0] en_bits
);

  logic [15:0]          cnt_mem [NUM_SLOTS];
  logic [15:0]          per_mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] cnt_seen;
  logic [NUM_SLOTS-1:0] per_seen;
  logic [15:0]          cnt_q;
  logic [15:0]          per_q;
  logic                 cnt_seen_q;
  logic                 per_seen_q;
  logic [AW-1:0]        addr_q;

  always_ff @(posedge clk) begin
    if (ctl.cnt_we) begin
      cnt_mem[wr_addr] <= cnt_wdata;
    end
    if (ctl.per_we) begin
      per_mem[wr_addr] <= per_wdata;
    end
    if (ctl.rd) begin
      cnt_q      <= cnt_mem[rd_addr];
      per_q      <= per_mem[rd_addr];
      cnt_seen_q <= cnt_seen[rd_addr];
      per_seen_q <= per_seen[rd_addr];
      addr_q     <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_seen <= '0;
      per_seen <= '0;
      en_bits  <= '1;
    end else begin
      if (ctl.cnt_we) begin
        cnt_seen[wr_addr] <= 1'b1;
      end
      if (ctl.per_we) begin
        per_seen[wr_addr] <= 1'b1;
      end
      if (ctl.en_we) begin
        en_bits[wr_addr] <= ctl.en_val;
      end
    end
  end

  assign cnt_rdata = cnt_seen_q ? cnt_q : psch_pkg::cnt_init(4'(addr_q));
  assign per_rdata = per_seen_q ? per_q : psch_pkg::per_init(4'(addr_q));

endmodule

// ===== sv/psch_ctrl.sv =====
// sequencer: command decode, slot scan with read-modify-write pipeline,
// result holding stage that marks the final fire of a tick
// depends on psch_pkg
module psch_ctrl #(
  parameter int NUM_SLOTS = psch_pkg::NUM_SLOTS_DEF,
  parameter int AW        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  psch_pkg::cmd_t        cmd,
  output logic                  busy,
  output psch_pkg::res_t        res,
  output logic                  res_strobe,
  output psch_pkg::store_ctl_t  ctl,
  output logic [AW-1:0]         rd_addr,
  output logic [AW-1:0]         wr_addr,
  output logic [15:0]           cnt_wdata,
  output logic [15:0]           per_wdata,
  input  logic [15:0]           cnt_rdata,
  input  logic [15:0]           per_rdata,
  input  logic [NUM_SLOTS-1:0]  en_bits
);

  localparam int FW = $clog2(psch_pkg::MAX_FIRE + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(NUM_SLOTS - 1);
  localparam logic [4:0]    NS5      = 5'(NUM_SLOTS);

  psch_pkg::state_t state;
  psch_pkg::state_t state_next;
  psch_pkg::cmd_t   cmd_q;
  logic [AW-1:0]    idx;
  logic             s1_valid;
  logic [AW-1:0]    s1_idx;
  logic             pend_valid;
  logic [2:0]       pend_slot;
  logic [FW-1:0]    fire_cnt;
  logic             accept;
  logic             fire;
  logic             fire_take;
  logic [4:0]       spec5;
  logic [4:0]       s1_idx5;
  logic [AW-1:0]    spec_addr;
  logic             spec_hit;
  logic [15:0]      per_sat;

  assign busy      = (state != psch_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign spec5     = {2'b00, cmd_q.spec};
  assign spec_addr = spec5[AW-1:0];
  assign spec_hit  = (spec5 < NS5);
  assign s1_idx5   = 5'(s1_idx);
  assign per_sat   = (cmd_q.period == 16'd0) ? 16'd1 : cmd_q.period;
  assign fire_take = fire && (fire_cnt < FW'(psch_pkg::MAX_FIRE));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      psch_pkg::ST_IDLE: begin
        if (start) begin
          case (cmd.op)
            psch_pkg::OP_TICK:    state_next = psch_pkg::ST_SCAN;
            psch_pkg::OP_SET_EN:  state_next = psch_pkg::ST_SET_RD;
            psch_pkg::OP_SET_PER: state_next = psch_pkg::ST_SET_RD;
            default:              state_next = psch_pkg::ST_IDLE;
          endcase
        end
      end
      psch_pkg::ST_SCAN: begin
        if (idx == LAST_IDX) begin
          state_next = psch_pkg::ST_DRAIN;
        end
      end
      psch_pkg::ST_DRAIN:  state_next = psch_pkg::ST_FLUSH;
      psch_pkg::ST_FLUSH:  state_next = psch_pkg::ST_IDLE;
      psch_pkg::ST_SET_RD: state_next = psch_pkg::ST_SET_WR;
      psch_pkg::ST_SET_WR: state_next = psch_pkg::ST_IDLE;
      default:             state_next = psch_pkg::ST_IDLE;
    endcase
  end

  // memory access and slot update
  always_comb begin
    ctl       = '0;
    rd_addr   = idx;
    wr_addr   = spec_addr;
    cnt_wdata = '0;
    per_wdata = per_sat;
    fire      = 1'b0;
    case (state)
      psch_pkg::ST_SCAN: begin
        ctl.rd  = 1'b1;
        rd_addr = idx;
      end
      psch_pkg::ST_SET_RD: begin
        ctl.rd  = 1'b1;
        rd_addr = spec_addr;
      end
      psch_pkg::ST_SET_WR: begin
        if (spec_hit) begin
          if (cmd_q.op == psch_pkg::OP_SET_EN) begin
            ctl.en_we  = 1'b1;
            ctl.en_val = cmd_q.enable;
            if (cmd_q.enable) begin
              ctl.cnt_we = 1'b1;
              cnt_wdata  = per_rdata - 16'd1;
            end
          end else if (cmd_q.op == psch_pkg::OP_SET_PER) begin
            ctl.per_we = 1'b1;
            ctl.cnt_we = 1'b1;
            cnt_wdata  = per_sat - 16'd1;
          end
        end
      end
      default: ;
    endcase
    if (s1_valid && en_bits[s1_idx]) begin
      ctl.cnt_we = 1'b1;
      wr_addr    = s1_idx;
      if (cnt_rdata != 16'd0) begin
        cnt_wdata = cnt_rdata - 16'd1;
      end else begin
        cnt_wdata = per_rdata - 16'd1;
        fire      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_idx   <= idx;
    res.slot <= pend_slot;
    res.tag  <= pend_slot;
    res.last <= (state == psch_pkg::ST_FLUSH);
    if (accept) begin
      cmd_q <= cmd;
    end
    if (fire_take) begin
      pend_slot <= s1_idx5[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= psch_pkg::ST_IDLE;
      idx        <= '0;
      s1_valid   <= 1'b0;
      pend_valid <= 1'b0;
      fire_cnt   <= '0;
      res_strobe <= 1'b0;
    end else begin
      state      <= state_next;
      s1_valid   <= (state == psch_pkg::ST_SCAN);
      res_strobe <= pend_valid && (fire_take || (state == psch_pkg::ST_FLUSH));
      if (accept) begin
        idx      <= '0;
        fire_cnt <= '0;
      end else if (state == psch_pkg::ST_SCAN) begin
        idx <= idx + AW'(1);
      end
      if (fire_take) begin
        pend_valid <= 1'b1;
        fire_cnt   <= fire_cnt + FW'(1);
      end else if (state == psch_pkg::ST_FLUSH) begin
        pend_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/periodic_message_scheduler.sv =====
// Periodic message scheduler. A tick command walks the slot table one slot per
// cycle through a read-modify-write pass over the countdown and period
// memories; busy stays high through the scan, drain and flush states of a tick
// and through the read and write states of a set-enable or set-period command.
// Fired slots come out in slot order, at most one per cycle, each on res for a
// single cycle with res_strobe high and no way to hold them off; the final one
// of a tick has res.last set and is on res in the first cycle with busy low. At
// most seven results are reported per tick. Set commands address the slot whose
// index equals spec.
module periodic_message_scheduler #(
  parameter int NUM_SLOTS = psch_pkg::NUM_SLOTS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  psch_pkg::cmd_t cmd,
  output logic           busy,
  output psch_pkg::res_t res,
  output logic           res_strobe
);

  localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  psch_pkg::store_ctl_t ctl;
  logic [AW-1:0]        rd_addr;
  logic [AW-1:0]        wr_addr;
  logic [15:0]          cnt_wdata;
  logic [15:0]          per_wdata;
  logic [15:0]          cnt_rdata;
  logic [15:0]          per_rdata;
  logic [NUM_SLOTS-1:0] en_bits;

  psch_ctrl #(
    .NUM_SLOTS (NUM_SLOTS),
    .AW        (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .cmd        (cmd),
    .busy       (busy),
    .res        (res),
    .res_strobe (res_strobe),
    .ctl        (ctl),
    .rd_addr    (rd_addr),
    .wr_addr    (wr_addr),
    .cnt_wdata  (cnt_wdata),
    .per_wdata  (per_wdata),
    .cnt_rdata  (cnt_rdata),
    .per_rdata  (per_rdata),
    .en_bits    (en_bits)
  );

  psch_store #(
    .NUM_SLOTS (NUM_SLOTS),
    .AW        (AW)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .cnt_wdata (cnt_wdata),
    .per_wdata (per_wdata),
    .cnt_rdata (cnt_rdata),
    .per_rdata (per_rdata),
    .en_bits   (en_bits)
  );

`ifndef SYNTH
  // results only come from a transfer in progress
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    res_strobe |-> $past(busy))
    else $error("result strobe without a command in progress");

  // nothing follows the final result of a tick
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (res_strobe && res.last) |=> !res_strobe)
    else $error("result after the final one of a tick");

  // a valid command transfer makes the block busy
  a_cmd_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (cmd.op == psch_pkg::OP_TICK || cmd.op == psch_pkg::OP_SET_EN
      || cmd.op == psch_pkg::OP_SET_PER)) |=> busy)
    else $error("command transfer did not raise busy");
`endif

endmodule
